>>> hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer package
// Screen geometry, derived widths, cell codes and the control and status
// structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	// Derived widths.
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	// Field widths of the item channels.
	localparam int OPCODE_W = 1;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int CROW_W   = 5;
	localparam int CCOL_W   = 7;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	// Operation codes.
	localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

	// Character and attribute codes.
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_we;   // write a reset blank at the sweep pointer
		logic exec;       // an item is accepted this cycle
		logic load_copy;  // start the pointer at the second row
		logic load_fill;  // start the pointer at the bottom row
		logic ptr_inc;    // advance the sweep pointer
		logic copy_rd;    // read the cell at the pointer for the scroll copy
		logic fill_we;    // blank the cell at the pointer
		logic load_out;   // load the result register
	} tcw_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ptr_last;     // pointer is at the last cell
		logic need_scroll;  // the item being accepted scrolls the screen
		logic out_free;     // the result register can take a new item
	} tcw_sts_t;

endpackage

>>> hdl/tcw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer channels
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_code;
	logic [4:0] cell_row;
	logic [6:0] cell_col;

	modport source (output valid, output opcode, output char_code, output cell_row,
		output cell_col, input ready);
	modport sink (input valid, input opcode, input char_code, input cell_row,
		input cell_col, output ready);
endinterface

interface tcw_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;
	logic [4:0] cursor_row;
	logic [6:0] cursor_col;
	logic       scrolled;

	modport source (output valid, output cell_char, output cell_attr, output cursor_row,
		output cursor_col, output scrolled, input ready);
	modport sink (input valid, input cell_char, input cell_attr, input cursor_row,
		input cursor_col, input scrolled, output ready);
endinterface

>>> hdl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer datapath
// Screen memory, cursor, attribute register, sweep pointer for clearing and
// scrolling, and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tcw_pkg::tcw_ctl_t        ctl,
	output tcw_pkg::tcw_sts_t        sts,
	input  logic                     cfg_we,
	input  logic [7:0]               cfg_data,
	input  logic                     opcode,
	input  logic [7:0]               char_code,
	input  logic [4:0]               cell_row,
	input  logic [6:0]               cell_col,
	tcw_rsp_if.source                rsp
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;

	logic [ATTR_W-1:0] attr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] ptr_q;

	logic              op_q;
	logic              rd_ok_q;
	logic              scrolled_q;

	logic              wr_en_s1;
	logic              wr_copy_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic              out_valid_q;

	logic              is_put;
	logic              is_newline;
	logic              col_last;
	logic              row_last;
	logic              row_adv;
	logic              rd_in_range;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] req_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;

	// Decode of the item on the command channel and the cursor position.
	always_comb begin
		is_put      = (opcode == OP_PUT);
		is_newline  = (char_code == NEWLINE_CODE);
		col_last    = (col_q == COL_W'(COLUMNS - 1));
		row_last    = (row_q == ROW_W'(ROWS - 1));
		row_adv     = is_newline || col_last;
		rd_in_range = (32'(cell_row) < 32'(ROWS)) && (32'(cell_col) < 32'(COLUMNS));
		cur_addr    = ADDR_W'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
		req_addr    = ADDR_W'(32'(cell_row) * 32'(COLUMNS) + 32'(cell_col));
	end

	assign sts.ptr_last    = (ptr_q == ADDR_W'(CELL_COUNT - 1));
	assign sts.need_scroll = is_put && row_adv && row_last;
	assign sts.out_free    = !out_valid_q || rsp.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_we) begin
			attr_q <= cfg_data;
		end
	end

	// Cursor update on an accepted put item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.exec && is_put) begin
			if (row_adv) begin
				col_q <= '0;
				if (!row_last) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Sweep pointer for the reset clear, the scroll copy and the blank fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.load_copy) begin
			ptr_q <= ADDR_W'(COLUMNS);
		end else if (ctl.load_fill) begin
			ptr_q <= ADDR_W'((ROWS - 1) * COLUMNS);
		end else if (ctl.ptr_inc) begin
			ptr_q <= ptr_q + ADDR_W'(1);
		end
	end

	// Delayed write stage: a copied cell is written one row up once its read
	// data is back, and blank fill writes ride the same stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= ctl.copy_rd || ctl.fill_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_copy_s1 <= ctl.copy_rd;
		wr_addr_s1 <= ctl.copy_rd ? (ptr_q - ADDR_W'(COLUMNS)) : ptr_q;
	end

	// Memory write port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = wr_copy_s1 ? rdata_q : {attr_q, BLANK_CODE};
		if (ctl.clear_we) begin
			mem_we    = 1'b1;
			mem_waddr = ptr_q;
			mem_wdata = {RESET_ATTR, BLANK_CODE};
		end else if (ctl.exec && is_put && !is_newline) begin
			mem_we    = 1'b1;
			mem_waddr = cur_addr;
			mem_wdata = {attr_q, char_code};
		end else if (wr_en_s1) begin
			mem_we    = 1'b1;
		end
	end

	assign rd_addr = ctl.copy_rd ? ptr_q : req_addr;
	assign rd_en   = ctl.copy_rd || (ctl.exec && !is_put);

	// Screen memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Per-item flags kept until the result is loaded.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			op_q       <= opcode;
			rd_ok_q    <= rd_in_range;
			scrolled_q <= sts.need_scroll;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if ((op_q == OP_READ) && rd_ok_q) begin
				rsp.cell_char <= rdata_q[CHAR_W-1:0];
				rsp.cell_attr <= rdata_q[CELL_W-1:CHAR_W];
			end else begin
				rsp.cell_char <= '0;
				rsp.cell_attr <= '0;
			end
			rsp.cursor_row <= CROW_W'(row_q);
			rsp.cursor_col <= CCOL_W'(col_q);
			rsp.scrolled   <= (op_q == OP_PUT) && scrolled_q;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

>>> hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer controller
// Sequences the reset clear, item execution, the scroll copy and fill, and
// the hand-off of each result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcw_pkg::tcw_sts_t   sts,
	output tcw_pkg::tcw_ctl_t   ctl
);
	import tcw_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_COPY  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_we = 1'b1;
				ctl.ptr_inc  = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.exec = 1'b1;
					if (sts.need_scroll) begin
						ctl.load_copy = 1'b1;
						state_d       = ST_COPY;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_COPY: begin
				ctl.copy_rd = 1'b1;
				if (sts.ptr_last) begin
					ctl.load_fill = 1'b1;
					state_d       = ST_FILL;
				end else begin
					ctl.ptr_inc = 1'b1;
				end
			end
			ST_FILL: begin
				ctl.fill_we = 1'b1;
				ctl.ptr_inc = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/text_console_char_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer
// Character-cell screen with a cursor: puts characters, handles newline and
// wrap, scrolls up past the bottom row, and reads back single cells.
//
//   Port      Direction  Carries
//   cmd       in         opcode, char_code, cell_row, cell_col
//   rsp       out        cell_char, cell_attr, cursor_row, cursor_col, scrolled
//   cfg_*     in         text_attribute write (cfg_we, cfg_data)
//
// A put or read item does its memory access in the accept cycle; the result
// register is loaded in the done state once it is free.
// A scrolling put runs the accept cycle, the copy of rows 1 to ROWS-1 one row
// up through the screen memory's one read port, one cell a cycle, the blank
// fill of the bottom row, and the result load.
// After reset a clearing pass blanks the screen; no item is accepted until it
// ends, configuration writes are taken throughout.
// A stalled result waits in the result register while the next item is taken.
// ----------------------------------------------------------------------------
module text_console_char_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	tcw_cmd_if.sink     cmd,
	tcw_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data
);
	import tcw_pkg::*;

	tcw_ctl_t ctl;
	tcw_sts_t sts;
	logic     in_ready;

	// Control sequencing.
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	assign cmd.ready = in_ready;

	// Screen, cursor and result datapath.
	tcw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.opcode    (cmd.opcode),
		.char_code (cmd.char_code),
		.cell_row  (cmd.cell_row),
		.cell_col  (cmd.cell_col),
		.rsp       (rsp)
	);

	// An accepted item blocks the next one: ready is low in the cycle after an accept.
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command channel ready right after an accept");

	// No sweep activity while the block is open for items.
	a_idle_no_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (!ctl.copy_rd && !ctl.fill_we && !ctl.clear_we))
		else $error("sweep active while accepting items");

	// A scroll leaves the cursor on the bottom row.
	a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.scrolled) |-> (rsp.cursor_row == 5'(ROWS - 1)))
		else $error("scrolled result with cursor off the bottom row");

	// A result is loaded only into a free result register.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten while pending");

endmodule
